// File: hdl/prmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prmt_pkg: shared definitions of the page region map table
// command and status codes, datapath operations and control structs
// ----------------------------------------------------------------------------
package prmt_pkg;

  localparam int unsigned MAX_REGIONS_DEF = 64;
  localparam int unsigned PAGE_BITS_DEF   = 20;
  localparam int unsigned USER_LOW_RST    = 1024;
  localparam int unsigned USER_HIGH_RST   = 786432;

  // commands
  localparam logic [2:0] CMD_MAP    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_EMPTY  = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // result status
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_RANGE = 3'd4;

  // register indexes
  localparam logic REG_USER_LOW  = 1'b0;
  localparam logic REG_USER_HIGH = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BAD,
    OP_CLEAR,
    OP_SCAN_INIT,
    OP_LOOK,
    OP_LOOK_FIN,
    OP_GAP_ENT,
    OP_GAP_LAST,
    OP_GAP_FIN,
    OP_CUT_A,
    OP_CUT_B,
    OP_CUT_C,
    OP_CUT_TAIL,
    OP_CUT_FIN
  } op_e;

  typedef struct packed {
    logic load;
    logic rd;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       page_zero;
    logic       count_zero;
    logic       range_ok;
    logic       scan_end;
    logic       stop;
    logic       found;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/prmt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prmt_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module prmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hdl/prmt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prmt_ctrl: command sequencer
// walks the region table through the datapath one entry at a time
// ----------------------------------------------------------------------------
module prmt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire prmt_pkg::dp_stat_t stat_i,
  output prmt_pkg::dp_cmd_t       cmd_o,
  output logic                    busy_o,
  output logic                    done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOOK_LOOP,
    S_LOOK_EVAL,
    S_LOOK_FIN,
    S_GAP_LOOP,
    S_GAP_EVAL,
    S_GAP_FIN,
    S_CUT_LOOP,
    S_CUT_A,
    S_CUT_B,
    S_CUT_C,
    S_CUT_TAIL,
    S_CUT_FIN,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;

  always_comb begin
    state_d   = state_q;
    cmd_o.load = 1'b0;
    cmd_o.rd   = 1'b0;
    cmd_o.op   = prmt_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d  = S_RESP;
        cmd_o.op = prmt_pkg::OP_BAD;
        case (stat_i.cmd)
          prmt_pkg::CMD_MAP: begin
            if (stat_i.page_zero) begin
              if (!stat_i.count_zero) begin
                cmd_o.op = prmt_pkg::OP_SCAN_INIT;
                state_d  = S_GAP_LOOP;
              end
            end else if (stat_i.range_ok) begin
              cmd_o.op = prmt_pkg::OP_SCAN_INIT;
              state_d  = S_CUT_LOOP;
            end
          end
          prmt_pkg::CMD_REMOVE: begin
            if (stat_i.range_ok) begin
              cmd_o.op = prmt_pkg::OP_SCAN_INIT;
              state_d  = S_CUT_LOOP;
            end
          end
          prmt_pkg::CMD_LOOKUP: begin
            cmd_o.op = prmt_pkg::OP_SCAN_INIT;
            state_d  = S_LOOK_LOOP;
          end
          prmt_pkg::CMD_FIND: begin
            if (!stat_i.count_zero) begin
              cmd_o.op = prmt_pkg::OP_SCAN_INIT;
              state_d  = S_GAP_LOOP;
            end
          end
          prmt_pkg::CMD_EMPTY: begin
            if (stat_i.range_ok) begin
              cmd_o.op = prmt_pkg::OP_SCAN_INIT;
              state_d  = S_LOOK_LOOP;
            end
          end
          prmt_pkg::CMD_CLEAR: begin
            cmd_o.op = prmt_pkg::OP_CLEAR;
          end
          default: begin
            cmd_o.op = prmt_pkg::OP_BAD;
          end
        endcase
      end
      S_LOOK_LOOP: begin
        if (stat_i.scan_end) begin
          state_d = S_LOOK_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_LOOK_EVAL;
        end
      end
      S_LOOK_EVAL: begin
        cmd_o.op = prmt_pkg::OP_LOOK;
        state_d  = stat_i.stop ? S_LOOK_FIN : S_LOOK_LOOP;
      end
      S_LOOK_FIN: begin
        cmd_o.op = prmt_pkg::OP_LOOK_FIN;
        state_d  = S_RESP;
      end
      S_GAP_LOOP: begin
        if (stat_i.scan_end) begin
          cmd_o.op = prmt_pkg::OP_GAP_LAST;
          state_d  = S_GAP_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_GAP_EVAL;
        end
      end
      S_GAP_EVAL: begin
        cmd_o.op = prmt_pkg::OP_GAP_ENT;
        state_d  = stat_i.stop ? S_GAP_FIN : S_GAP_LOOP;
      end
      S_GAP_FIN: begin
        cmd_o.op = prmt_pkg::OP_GAP_FIN;
        state_d  = (stat_i.found && stat_i.cmd == prmt_pkg::CMD_MAP) ? S_CUT_LOOP : S_RESP;
      end
      S_CUT_LOOP: begin
        if (stat_i.scan_end) begin
          state_d = S_CUT_TAIL;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_CUT_A;
        end
      end
      S_CUT_A: begin
        cmd_o.op = prmt_pkg::OP_CUT_A;
        state_d  = S_CUT_B;
      end
      S_CUT_B: begin
        cmd_o.op = prmt_pkg::OP_CUT_B;
        state_d  = S_CUT_C;
      end
      S_CUT_C: begin
        cmd_o.op = prmt_pkg::OP_CUT_C;
        state_d  = S_CUT_LOOP;
      end
      S_CUT_TAIL: begin
        cmd_o.op = prmt_pkg::OP_CUT_TAIL;
        state_d  = S_CUT_FIN;
      end
      S_CUT_FIN: begin
        cmd_o.op = prmt_pkg::OP_CUT_FIN;
        state_d  = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= (state_d == S_RESP);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: hdl/prmt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prmt_dp: region table datapath
// double banked table ram, scan compare logic, gap search and result registers
// ----------------------------------------------------------------------------
module prmt_dp #(
  parameter int unsigned MAX_REGIONS      = prmt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned PAGE_NUMBER_BITS = prmt_pkg::PAGE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [PAGE_NUMBER_BITS-1:0] low_i,
  input  wire logic [PAGE_NUMBER_BITS-1:0] high_i,
  input  wire logic [2:0]                  command_i,
  input  wire logic [PAGE_NUMBER_BITS-1:0] page_i,
  input  wire logic [PAGE_NUMBER_BITS:0]   page_count_i,
  input  wire logic                        direction_i,
  input  wire logic [2:0]                  protection_i,
  input  wire logic                        shared_i,
  input  wire logic [PAGE_NUMBER_BITS-1:0] file_offset_i,
  input  wire prmt_pkg::dp_cmd_t           cmd_i,
  output prmt_pkg::dp_stat_t               stat_o,
  output logic [2:0]                       status_o,
  output logic                             range_free_o,
  output logic [PAGE_NUMBER_BITS-1:0]      region_start_o,
  output logic [PAGE_NUMBER_BITS-1:0]      region_end_o,
  output logic [PAGE_NUMBER_BITS-1:0]      region_offset_o,
  output logic [2:0]                       region_protection_o,
  output logic                             region_shared_o
);

  localparam int unsigned PB = PAGE_NUMBER_BITS;
  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned EW = 3 * PB + 4;
  localparam int unsigned RAM_DEPTH = 2 ** (IW + 1);

  // latched item
  logic [2:0]    cmd_q;
  logic [PB-1:0] page_q, off_q;
  logic [PB:0]   cnt_q;
  logic          dir_q, sh_q;
  logic [2:0]    prot_q;

  // table and scan state
  logic [CW-1:0] tab_cnt_q, idx_q, wcnt_q;
  logic          bank_q, hit_q, found_q, ins_q, full_q;
  logic [PB:0]   cursor_q;
  logic [PB-1:0] lo_q, hi_q, gap_s_q;

  // result
  logic [2:0]    res_st_q, res_p_q;
  logic          res_free_q, res_sh_q;
  logic [PB-1:0] res_s_q, res_e_q, res_o_q;

  logic          we;
  logic [EW-1:0] wdata, rdata;
  logic [PB-1:0] rd_s, rd_e, rd_o;
  logic [2:0]    rd_p;
  logic          rd_sh;

  prmt_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({~bank_q, wcnt_q[IW-1:0]}),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i ({bank_q, idx_q[IW-1:0]}),
    .rdata_o (rdata)
  );

  assign rd_s  = rdata[EW-1 -: PB];
  assign rd_e  = rdata[EW-1-PB -: PB];
  assign rd_o  = rdata[EW-1-2*PB -: PB];
  assign rd_p  = rdata[3:1];
  assign rd_sh = rdata[0];

  logic          ovl, is_map, fit, rng_ok, wfull, emit;
  logic [PB:0]   lim, ga, gb, gdiff, gsub, end_p1;
  logic [PB+1:0] rng_sum;
  logic [PB-1:0] gstart, hi_page, gap_hi;

  always_comb begin
    is_map  = (cmd_q == prmt_pkg::CMD_MAP);
    ovl     = !((rd_e < lo_q) || (rd_s > hi_q));
    lim     = (cmd_i.op == prmt_pkg::OP_GAP_LAST) ? {1'b0, high_i} : {1'b0, rd_s};
    ga      = (cursor_q > {1'b0, low_i}) ? cursor_q : {1'b0, low_i};
    gb      = (lim < {1'b0, high_i}) ? lim : {1'b0, high_i};
    gdiff   = gb - ga;
    fit     = (gb > ga) && (gdiff >= cnt_q);
    gsub    = gb - cnt_q;
    gstart  = dir_q ? gsub[PB-1:0] : ga[PB-1:0];
    end_p1  = {1'b0, rd_e} + (PB+1)'(1);
    rng_sum = {2'b00, page_q} + {1'b0, cnt_q};
    rng_ok  = (cnt_q != '0) && (page_q >= low_i) && (rng_sum <= {2'b00, high_i});
    hi_page = page_q + cnt_q[PB-1:0] - PB'(1);
    gap_hi  = gap_s_q + cnt_q[PB-1:0] - PB'(1);
    wfull   = (wcnt_q == CW'(MAX_REGIONS));
  end

  // piece emitted into the other bank during a cut pass
  always_comb begin
    emit  = 1'b0;
    wdata = rdata;
    case (cmd_i.op)
      prmt_pkg::OP_CUT_A: begin
        emit  = ovl && (rd_s < lo_q);
        wdata = {rd_s, lo_q - PB'(1), rd_o, rd_p, rd_sh};
      end
      prmt_pkg::OP_CUT_B: begin
        emit  = is_map && !ins_q && ((!ovl && rd_s > hi_q) || (ovl && rd_e > hi_q));
        wdata = {lo_q, hi_q, off_q, prot_q, sh_q};
      end
      prmt_pkg::OP_CUT_C: begin
        emit = !ovl || (rd_e > hi_q);
        if (ovl) begin
          wdata = {hi_q + PB'(1), rd_e, rd_o + hi_q + PB'(1) - rd_s, rd_p, rd_sh};
        end
      end
      prmt_pkg::OP_CUT_TAIL: begin
        emit  = is_map && !ins_q;
        wdata = {lo_q, hi_q, off_q, prot_q, sh_q};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    we = emit && !wfull;
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.page_zero  = (page_q == '0);
    stat_o.count_zero = (cnt_q == '0);
    stat_o.range_ok   = rng_ok;
    stat_o.scan_end   = (idx_q == tab_cnt_q);
    stat_o.stop       = ((cmd_i.op == prmt_pkg::OP_LOOK) && ovl) ||
                        ((cmd_i.op == prmt_pkg::OP_GAP_ENT) && fit && !dir_q);
    stat_o.found      = found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= '0;
      page_q     <= '0;
      cnt_q      <= '0;
      dir_q      <= 1'b0;
      prot_q     <= '0;
      sh_q       <= 1'b0;
      off_q      <= '0;
      tab_cnt_q  <= '0;
      idx_q      <= '0;
      wcnt_q     <= '0;
      bank_q     <= 1'b0;
      hit_q      <= 1'b0;
      found_q    <= 1'b0;
      ins_q      <= 1'b0;
      full_q     <= 1'b0;
      cursor_q   <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      gap_s_q    <= '0;
      res_st_q   <= '0;
      res_free_q <= 1'b0;
      res_s_q    <= '0;
      res_e_q    <= '0;
      res_o_q    <= '0;
      res_p_q    <= '0;
      res_sh_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cmd_q      <= command_i;
        page_q     <= page_i;
        cnt_q      <= page_count_i;
        dir_q      <= direction_i;
        prot_q     <= protection_i;
        sh_q       <= shared_i;
        off_q      <= file_offset_i;
        res_st_q   <= prmt_pkg::ST_OK;
        res_free_q <= 1'b0;
        res_s_q    <= '0;
        res_e_q    <= '0;
        res_o_q    <= '0;
        res_p_q    <= '0;
        res_sh_q   <= 1'b0;
      end
      if (emit) begin
        if (wfull) begin
          full_q <= 1'b1;
        end else begin
          wcnt_q <= wcnt_q + CW'(1);
        end
      end
      case (cmd_i.op)
        prmt_pkg::OP_BAD: begin
          res_st_q <= prmt_pkg::ST_BAD_RANGE;
        end
        prmt_pkg::OP_CLEAR: begin
          tab_cnt_q <= '0;
        end
        prmt_pkg::OP_SCAN_INIT: begin
          idx_q    <= '0;
          wcnt_q   <= '0;
          hit_q    <= 1'b0;
          found_q  <= 1'b0;
          ins_q    <= 1'b0;
          full_q   <= 1'b0;
          cursor_q <= {1'b0, low_i};
          lo_q     <= page_q;
          hi_q     <= (cmd_q == prmt_pkg::CMD_LOOKUP) ? page_q : hi_page;
        end
        prmt_pkg::OP_LOOK: begin
          idx_q <= idx_q + CW'(1);
          if (ovl) begin
            hit_q   <= 1'b1;
            res_s_q <= rd_s;
            res_e_q <= rd_e;
            res_o_q <= rd_o;
            res_p_q <= rd_p;
            res_sh_q <= rd_sh;
          end
        end
        prmt_pkg::OP_LOOK_FIN: begin
          if (cmd_q == prmt_pkg::CMD_LOOKUP) begin
            res_st_q <= hit_q ? prmt_pkg::ST_OK : prmt_pkg::ST_NOT_FOUND;
          end else begin
            // range empty query reports no region fields
            res_free_q <= !hit_q;
            res_s_q    <= '0;
            res_e_q    <= '0;
            res_o_q    <= '0;
            res_p_q    <= '0;
            res_sh_q   <= 1'b0;
          end
        end
        prmt_pkg::OP_GAP_ENT: begin
          idx_q <= idx_q + CW'(1);
          if (end_p1 > cursor_q) begin
            cursor_q <= end_p1;
          end
          if (fit) begin
            found_q <= 1'b1;
            gap_s_q <= gstart;
          end
        end
        prmt_pkg::OP_GAP_LAST: begin
          if (fit) begin
            found_q <= 1'b1;
            gap_s_q <= gstart;
          end
        end
        prmt_pkg::OP_GAP_FIN: begin
          if (!found_q) begin
            res_st_q <= prmt_pkg::ST_NO_SPACE;
          end else if (cmd_q == prmt_pkg::CMD_FIND) begin
            res_s_q <= gap_s_q;
            res_e_q <= gap_hi;
          end else begin
            lo_q  <= gap_s_q;
            hi_q  <= gap_hi;
            idx_q <= '0;
          end
        end
        prmt_pkg::OP_CUT_B: begin
          if (emit) begin
            ins_q <= 1'b1;
          end
        end
        prmt_pkg::OP_CUT_C: begin
          idx_q <= idx_q + CW'(1);
        end
        prmt_pkg::OP_CUT_FIN: begin
          if (full_q) begin
            res_st_q <= prmt_pkg::ST_FULL;
          end else begin
            bank_q    <= ~bank_q;
            tab_cnt_q <= wcnt_q;
            if (is_map) begin
              res_s_q  <= lo_q;
              res_e_q  <= hi_q;
              res_o_q  <= off_q;
              res_p_q  <= prot_q;
              res_sh_q <= sh_q;
            end
          end
        end
        default: begin
          idx_q <= idx_q;
        end
      endcase
    end
  end

  assign status_o            = res_st_q;
  assign range_free_o        = res_free_q;
  assign region_start_o      = res_s_q;
  assign region_end_o        = res_e_q;
  assign region_offset_o     = res_o_q;
  assign region_protection_o = res_p_q;
  assign region_shared_o     = res_sh_q;

endmodule
`default_nettype wire

// File: hdl/page_region_map_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_region_map_table: start-sorted table of non-overlapping page regions
// map, remove, lookup, free range search, range empty query and clear
// ----------------------------------------------------------------------------
// channel   | direction | handshake                    | contents
// command   | in        | start / busy                 | command, page, count, attributes
// result    | out       | done_o strobe, one cycle     | status, range_free, region fields
// config    | in/out    | apb psel/penable, pready = 1 | user_low_page, user_high_page
//
// sequencing: one command at a time; a command is decoded, then walks the table.
//   lookup and range empty read and compare each entry visited, the gap search reads
//   and evaluates each entry, a cut pass (map, remove) reads each entry and runs steps
//   a, b and c on it, so map with automatic placement runs a gap search, then a cut pass
// reset: table empty, user bounds at their defaults, no table clearing pass
// stalls: done_o cannot be held off; busy stays high until the result strobe
// ----------------------------------------------------------------------------
module page_region_map_table #(
  parameter int unsigned MAX_REGIONS      = prmt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned PAGE_NUMBER_BITS = prmt_pkg::PAGE_BITS_DEF,
  localparam int unsigned APB_DW = (PAGE_NUMBER_BITS > 32) ? 64 : 32,
  localparam int unsigned APB_AW = (PAGE_NUMBER_BITS > 32) ? 4 : 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  command_i,
  input  wire logic [PAGE_NUMBER_BITS-1:0] page_i,
  input  wire logic [PAGE_NUMBER_BITS:0]   page_count_i,
  input  wire logic                        direction_i,
  input  wire logic [2:0]                  protection_i,
  input  wire logic                        shared_i,
  input  wire logic [PAGE_NUMBER_BITS-1:0] file_offset_i,
  // result channel
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic                             range_free_o,
  output logic [PAGE_NUMBER_BITS-1:0]      region_start_o,
  output logic [PAGE_NUMBER_BITS-1:0]      region_end_o,
  output logic [PAGE_NUMBER_BITS-1:0]      region_offset_o,
  output logic [2:0]                       region_protection_o,
  output logic                             region_shared_o,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [APB_AW-1:0]           paddr,
  input  wire logic [APB_DW-1:0]           pwdata,
  output logic [APB_DW-1:0]                prdata,
  output logic                             pready
);

  localparam int unsigned PB = PAGE_NUMBER_BITS;

  // user page bounds
  logic [PB-1:0] low_q, high_q;
  logic          cfg_wr;
  logic          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[APB_AW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= PB'(prmt_pkg::USER_LOW_RST);
      high_q <= PB'(prmt_pkg::USER_HIGH_RST);
    end else if (cfg_wr) begin
      if (cfg_sel == prmt_pkg::REG_USER_LOW) begin
        low_q <= pwdata[PB-1:0];
      end else begin
        high_q <= pwdata[PB-1:0];
      end
    end
  end

  // read back of the selected bound
  assign prdata = (cfg_sel == prmt_pkg::REG_USER_LOW) ? APB_DW'(low_q) : APB_DW'(high_q);

  prmt_pkg::dp_cmd_t  dp_cmd;
  prmt_pkg::dp_stat_t dp_stat;

  // sequencer: decodes the command and steps the table walk
  prmt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // datapath: banked table ram, compares and result registers
  prmt_dp #(
    .MAX_REGIONS      (MAX_REGIONS),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .low_i               (low_q),
    .high_i              (high_q),
    .command_i           (command_i),
    .page_i              (page_i),
    .page_count_i        (page_count_i),
    .direction_i         (direction_i),
    .protection_i        (protection_i),
    .shared_i            (shared_i),
    .file_offset_i       (file_offset_i),
    .cmd_i               (dp_cmd),
    .stat_o              (dp_stat),
    .status_o            (status_o),
    .range_free_o        (range_free_o),
    .region_start_o      (region_start_o),
    .region_end_o        (region_end_o),
    .region_offset_o     (region_offset_o),
    .region_protection_o (region_protection_o),
    .region_shared_o     (region_shared_o)
  );

  // a result strobe only ends a transaction that is still in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // an accepted transaction makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // the result strobe lasts one cycle and is followed by idle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // range free answer is only given with an ok status
  a_free_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_free_o) |-> (status_o == prmt_pkg::ST_OK))
    else $error("range free with error status");

endmodule
`default_nettype wire

// File: test/page_region_map_table_test.sv
// ----------------------------------------------------------------------------
// page_region_map_table_test: self-checking bench of the page region map table
// drives random and directed commands, writes the user page bounds between
// phases and checks every result against a scoreboard that predicts the table
// ----------------------------------------------------------------------------
module page_region_map_table_test;
  import prmt_pkg::*;

  localparam int unsigned NREG      = MAX_REGIONS_DEF;
  localparam int unsigned PHASE_LEN = 275;
  localparam longint     CYCLE_CAP = 3000000;

  // one expected or observed result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic        range_free;
    logic [19:0] rstart;
    logic [19:0] rend;
    logic [19:0] roffset;
    logic [2:0]  rprot;
    logic        rshared;
  } map_result_t;

  // scoreboard: keeps its own copy of the region table and the user bounds
  class map_table_scoreboard;
    typedef struct {
      longint unsigned spg[NREG];
      longint unsigned epg[NREG];
      longint unsigned opg[NREG];
      logic [2:0]      prot[NREG];
      logic            shr[NREG];
      int unsigned     n;
    } region_tbl_t;

    region_tbl_t     tbl;
    region_tbl_t     scratch;
    longint unsigned low_pg;
    longint unsigned high_pg;
    map_result_t     pending_q[$];
    int unsigned     errors;

    function new();
      tbl.n   = 0;
      low_pg  = USER_LOW_RST;
      high_pg = USER_HIGH_RST;
      errors  = 0;
    endfunction

    function bit range_ok(longint unsigned pg, longint unsigned cnt);
      return cnt >= 1 && pg >= low_pg && pg + cnt <= high_pg;
    endfunction

    function bit push(longint unsigned s, longint unsigned e, longint unsigned o,
                      logic [2:0] p, logic sh);
      if (scratch.n >= NREG) return 0;
      scratch.spg[scratch.n]  = s;
      scratch.epg[scratch.n]  = e;
      scratch.opg[scratch.n]  = o & 20'hFFFFF;
      scratch.prot[scratch.n] = p;
      scratch.shr[scratch.n]  = sh;
      scratch.n++;
      return 1;
    endfunction

    // copy of the table with pages lo..hi unmapped, into scratch
    function bit unmap_pages(longint unsigned lo, longint unsigned hi);
      longint unsigned s, e, o;
      scratch.n = 0;
      for (int unsigned i = 0; i < tbl.n; i++) begin
        s = tbl.spg[i];
        e = tbl.epg[i];
        o = tbl.opg[i];
        if (e < lo || s > hi) begin
          if (!push(s, e, o, tbl.prot[i], tbl.shr[i])) return 0;
        end else begin
          if (s < lo && !push(s, lo - 1, o, tbl.prot[i], tbl.shr[i])) return 0;
          // upper remainder: offset advances by the pages cut away
          if (e > hi && !push(hi + 1, e, o + (hi + 1 - s), tbl.prot[i], tbl.shr[i]))
            return 0;
        end
      end
      return 1;
    endfunction

    function bit insert_region(longint unsigned s, longint unsigned e, longint unsigned o,
                               logic [2:0] p, logic sh);
      int unsigned pos;
      pos = 0;
      if (scratch.n >= NREG) return 0;
      while (pos < scratch.n && scratch.spg[pos] < s) pos++;
      for (int unsigned k = scratch.n; k > pos; k--) begin
        scratch.spg[k]  = scratch.spg[k-1];
        scratch.epg[k]  = scratch.epg[k-1];
        scratch.opg[k]  = scratch.opg[k-1];
        scratch.prot[k] = scratch.prot[k-1];
        scratch.shr[k]  = scratch.shr[k-1];
      end
      scratch.spg[pos]  = s;
      scratch.epg[pos]  = e;
      scratch.opg[pos]  = o & 20'hFFFFF;
      scratch.prot[pos] = p;
      scratch.shr[pos]  = sh;
      scratch.n++;
      return 1;
    endfunction

    // first fit (last fit when dir is set) over the gaps inside the user bounds, bounds included
    function bit find_gap(longint unsigned cnt, logic dir, output longint unsigned pick);
      longint unsigned cursor, a, b, lim;
      bit found, last;
      cursor = low_pg;
      found  = 0;
      pick   = 0;
      for (int unsigned i = 0; i <= tbl.n; i++) begin
        last = (i == tbl.n);
        lim  = last ? high_pg : tbl.spg[i];
        a = cursor > low_pg ? cursor : low_pg;
        b = lim < high_pg ? lim : high_pg;
        if (b > a && b - a >= cnt) begin
          found = 1;
          if (!dir) begin
            pick = a;
            return 1;
          end
          pick = b - cnt;
        end
        if (last) break;
        if (tbl.epg[i] + 1 > cursor) cursor = tbl.epg[i] + 1;
      end
      return found;
    endfunction

    function void set_bound(logic idx, logic [19:0] value);
      if (idx == REG_USER_LOW) low_pg = value;
      else high_pg = value;
    endfunction

    // accepted command: predict its result and update the table
    function void note_command(logic [2:0] cmd, logic [19:0] pg, logic [20:0] cnt,
                               logic dir, logic [2:0] p, logic sh, logic [19:0] off);
      map_result_t     r;
      longint unsigned s, c;
      bit              go;
      r  = '0;
      c  = cnt;
      s  = pg;
      go = 0;
      case (cmd)
        CMD_MAP: begin
          if (pg == 0) begin
            if (c == 0) r.status = ST_BAD_RANGE;
            else if (!find_gap(c, dir, s)) r.status = ST_NO_SPACE;
            else go = 1;
          end else if (!range_ok(pg, c)) r.status = ST_BAD_RANGE;
          else go = 1;
          if (go) begin
            if (!unmap_pages(s, s + c - 1) || !insert_region(s, s + c - 1, off, p, sh)) begin
              r.status = ST_FULL;
            end else begin
              tbl       = scratch;
              r.rstart  = 20'(s);
              r.rend    = 20'(s + c - 1);
              r.roffset = off;
              r.rprot   = p;
              r.rshared = sh;
            end
          end
        end
        CMD_REMOVE: begin
          if (!range_ok(pg, c)) r.status = ST_BAD_RANGE;
          else if (!unmap_pages(pg, pg + c - 1)) r.status = ST_FULL;
          else tbl = scratch;
        end
        CMD_LOOKUP: begin
          r.status = ST_NOT_FOUND;
          for (int unsigned i = 0; i < tbl.n; i++) begin
            if (pg >= tbl.spg[i] && pg <= tbl.epg[i]) begin
              r.status  = ST_OK;
              r.rstart  = 20'(tbl.spg[i]);
              r.rend    = 20'(tbl.epg[i]);
              r.roffset = 20'(tbl.opg[i]);
              r.rprot   = tbl.prot[i];
              r.rshared = tbl.shr[i];
              break;
            end
          end
        end
        CMD_FIND: begin
          if (c == 0) r.status = ST_BAD_RANGE;
          else if (!find_gap(c, dir, s)) r.status = ST_NO_SPACE;
          else begin
            r.rstart = 20'(s);
            r.rend   = 20'(s + c - 1);
          end
        end
        CMD_EMPTY: begin
          if (!range_ok(pg, c)) r.status = ST_BAD_RANGE;
          else begin
            r.range_free = 1;
            for (int unsigned i = 0; i < tbl.n; i++)
              if (tbl.spg[i] <= pg + c - 1 && tbl.epg[i] >= pg) begin
                r.range_free = 0;
                break;
              end
          end
        end
        CMD_CLEAR: tbl.n = 0;
        default:   r.status = ST_BAD_RANGE;
      endcase
      pending_q.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("mismatch %0s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    endtask

    task check_result(map_result_t got);
      map_result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", got, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status) report("status", got.status, want.status);
      if (got.range_free != want.range_free)
        report("range_free", got.range_free, want.range_free);
      if (got.rstart != want.rstart) report("region_start", got.rstart, want.rstart);
      if (got.rend != want.rend) report("region_end", got.rend, want.rend);
      if (got.roffset != want.roffset) report("region_offset", got.roffset, want.roffset);
      if (got.rprot != want.rprot) report("region_protection", got.rprot, want.rprot);
      if (got.rshared != want.rshared) report("region_shared", got.rshared, want.rshared);
    endtask
  endclass

  // dut signals
  logic        clk, rst_n;
  logic        start, busy;
  logic [2:0]  command;
  logic [19:0] page;
  logic [20:0] page_count;
  logic        direction;
  logic [2:0]  protection;
  logic        shared;
  logic [19:0] file_offset;
  logic        done;
  logic [2:0]  status;
  logic        range_free;
  logic [19:0] region_start, region_end, region_offset;
  logic [2:0]  region_protection;
  logic        region_shared;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  map_table_scoreboard sb;
  longint              cycles;
  int unsigned         sent;

  page_region_map_table i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start               (start),
    .busy                (busy),
    .command_i           (command),
    .page_i              (page),
    .page_count_i        (page_count),
    .direction_i         (direction),
    .protection_i        (protection),
    .shared_i            (shared),
    .file_offset_i       (file_offset),
    .done_o              (done),
    .status_o            (status),
    .range_free_o        (range_free),
    .region_start_o      (region_start),
    .region_end_o        (region_end),
    .region_offset_o     (region_offset),
    .region_protection_o (region_protection),
    .region_shared_o     (region_shared),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on a generous cycle budget
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result strobe lasts one cycle, sample it at the closing edge
  always @(posedge clk) begin
    if (rst_n && done)
      sb.check_result('{status, range_free, region_start, region_end, region_offset,
                        region_protection, region_shared});
  end

  // one command transaction: random idle gap, then hold start until accepted
  task send_cmd(logic [2:0] cmd, logic [19:0] pg, logic [20:0] cnt, logic dir,
                logic [2:0] p, logic sh, logic [19:0] off);
    int unsigned gap;
    gap = $urandom_range(0, 11);
    // a share of back-to-back commands with no idling at all
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    command     = cmd;
    page        = pg;
    page_count  = cnt;
    direction   = dir;
    protection  = p;
    shared      = sh;
    file_offset = off;
    start       = 1;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, pg, cnt, dir, p, sh, off);
    sent++;
  endtask

  // drop start while the last command is still busy, then wait for every
  // outstanding result before touching the bounds
  task drain();
    @(negedge clk);
    start = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle, pready is always high
  task write_bound(logic idx, logic [19:0] value);
    drain();
    @(negedge clk);
    psel    = 1;
    penable = 0;
    pwrite  = 1;
    paddr   = {idx, 2'b00};
    pwdata  = {12'($urandom_range(0, 4095)), value};
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_bound(idx, value);
    @(negedge clk);
    psel    = 0;
    penable = 0;
    pwrite  = 0;
  endtask

  // random command biased toward the user window so regions collide
  task send_random();
    logic [2:0]      cmd;
    longint unsigned span, pg, cnt;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) cmd = CMD_MAP;
    else if (pick < 55) cmd = CMD_REMOVE;
    else if (pick < 70) cmd = CMD_LOOKUP;
    else if (pick < 81) cmd = CMD_FIND;
    else if (pick < 93) cmd = CMD_EMPTY;
    else if (pick < 96) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(6, 7));
    span = (sb.high_pg > sb.low_pg) ? sb.high_pg - sb.low_pg : 1;
    if (span > 600) span = 600;
    if ($urandom_range(0, 9) == 0) pg = $urandom & 20'hFFFFF;
    else pg = (sb.low_pg + $urandom_range(0, span - 1)) & 20'hFFFFF;
    pick = $urandom_range(0, 9);
    if (pick < 7) cnt = $urandom_range(1, 24);
    else if (pick == 7) cnt = $urandom_range(1, span);
    else if (pick == 8) cnt = $urandom & 21'h1FFFFF;
    else cnt = 0;
    // automatic placement in about a third of the maps
    if (cmd == CMD_MAP && $urandom_range(0, 2) == 0) pg = 0;
    send_cmd(cmd, 20'(pg), 21'(cnt), 1'($urandom), 3'($urandom), 1'($urandom),
             20'($urandom));
  endtask

  initial begin
    logic [19:0] lo_val [6];
    logic [19:0] hi_val [6];
    sb = new();
    sent = 0;
    rst_n = 0;
    start = 0;
    command = CMD_LOOKUP;
    page = 0;
    page_count = 0;
    direction = 0;
    protection = 0;
    shared = 0;
    file_offset = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed part under the reset bounds
    send_cmd(CMD_MAP, 0, 0, 0, 0, 0, 0);                    // automatic with zero count
    send_cmd(CMD_MAP, 0, 1, 0, 3'h7, 1, 20'hFFFFF);          // lowest gap
    send_cmd(CMD_MAP, 0, 1, 1, 3'h1, 0, 20'h00000);          // highest gap
    send_cmd(CMD_MAP, 2000, 100, 0, 3'h5, 1, 10);
    send_cmd(CMD_LOOKUP, 2050, 1, 0, 0, 0, 0);
    send_cmd(CMD_LOOKUP, 0, 1, 0, 0, 0, 0);                  // not mapped
    send_cmd(CMD_REMOVE, 2040, 10, 0, 0, 0, 0);              // split in the middle
    send_cmd(CMD_LOOKUP, 2060, 1, 0, 0, 0, 0);               // offset moved
    send_cmd(CMD_REMOVE, 1990, 20, 0, 0, 0, 0);              // trim at the start
    send_cmd(CMD_REMOVE, 2090, 20, 0, 0, 0, 0);              // trim at the end
    send_cmd(CMD_REMOVE, 2010, 30, 0, 0, 0, 0);              // delete whole region
    send_cmd(CMD_FIND, 0, 0, 0, 0, 0, 0);                    // zero count
    send_cmd(CMD_FIND, 0, 21'h1FFFFF, 0, 0, 0, 0);           // never fits
    send_cmd(CMD_FIND, 0, 5, 1, 0, 0, 0);
    send_cmd(CMD_FIND, 0, 21'h100000, 0, 0, 0, 0);
    send_cmd(CMD_EMPTY, 1024, 1, 0, 0, 0, 0);
    send_cmd(CMD_EMPTY, 1023, 1, 0, 0, 0, 0);                // below the user bound
    send_cmd(CMD_EMPTY, 5000, 10, 0, 0, 0, 0);
    send_cmd(CMD_MAP, 20'hFFFFF, 1, 0, 0, 0, 0);             // above the user bound
    send_cmd(CMD_MAP, 786431, 1, 0, 3'h2, 1, 20'h12345);     // overlays a region
    send_cmd(CMD_REMOVE, 1000, 100, 0, 0, 0, 0);             // invalid remove
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_cmd(3'd6, 0, 0, 0, 0, 0, 0);                         // unknown command
    send_cmd(3'd7, 20'hFFFFF, 21'h1FFFFF, 1, 3'h7, 1, 20'hFFFFF);
    send_cmd(CMD_LOOKUP, 1024, 1, 0, 0, 0, 0);

    // fill the table to capacity and overflow it by map, then trim one region and remove it
    write_bound(REG_USER_LOW, 16);
    write_bound(REG_USER_HIGH, 400);
    for (int k = 0; k <= NREG; k++)
      send_cmd(CMD_MAP, 20'(16 + 3 * k), 2, 0, 3'($urandom), 1'($urandom), 20'($urandom));
    send_cmd(CMD_MAP, 0, 1, 0, 0, 0, 0);
    send_cmd(CMD_REMOVE, 17, 1, 0, 0, 0, 0);
    send_cmd(CMD_REMOVE, 16, 2, 0, 0, 0, 0);

    // random phases over several bound settings, extremes among them
    lo_val = '{20'd1024, 20'd16, 20'd0, 20'd500, 20'd200, 20'hFFFFF};
    hi_val = '{20'd786432, 20'd300, 20'hFFFFF, 20'd500, 20'd100, 20'hFFFFF};
    for (int ph = 0; ph < 6; ph++) begin
      write_bound(REG_USER_LOW, lo_val[ph]);
      write_bound(REG_USER_HIGH, hi_val[ph]);
      send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      repeat (PHASE_LEN) send_random();
    end

    // let the last result arrive, then a short tail for stray strobes
    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d commands over six bound settings and a full-table overflow",
             sent);
    $display("all command codes, automatic placement both ways, splits and trims");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field mismatches", sb.errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/prmt_pkg.sv
hdl/prmt_ram.sv
hdl/prmt_ctrl.sv
hdl/prmt_dp.sv
hdl/page_region_map_table.sv
test/page_region_map_table_test.sv
